[rtl/core/lkv_pkg.sv]
package lkv_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths of the request and response words
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        MODE_GET   = 2'd0,
        MODE_PUT   = 2'd1,
        MODE_ERASE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
    } lkv_req_t;

    typedef struct packed {
        logic               found;
        logic [DATA_W-1:0]  value_out;
        logic [COUNT_W-1:0] entry_count;
    } lkv_rsp_t;

endpackage

[rtl/core/lkv_store.sv]
module lkv_store #(
    parameter int CAPACITY   = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd,
    input  lkv_pkg::lkv_req_t req,
    output lkv_pkg::lkv_rsp_t rsp
);
    import lkv_pkg::*;

    localparam int KW = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
    localparam int VW = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // rank 0 is most recent; valid ranks are always 0 .. count-1
    logic          valid_reg [CAPACITY];
    logic [KW-1:0] key_reg   [CAPACITY];
    logic [VW-1:0] val_reg   [CAPACITY];
    logic [RW-1:0] rank_reg  [CAPACITY];
    logic [CW-1:0] count_reg;

    logic          valid_next [CAPACITY];
    logic [KW-1:0] key_next   [CAPACITY];
    logic [VW-1:0] val_next   [CAPACITY];
    logic [RW-1:0] rank_next  [CAPACITY];
    logic [CW-1:0] count_next;

    logic [KW-1:0] k;
    logic [VW-1:0] v;
    logic          hit_any;
    logic [RW-1:0] hit_idx;
    logic [RW-1:0] hit_rank;
    logic [VW-1:0] hit_val;
    logic          full;
    logic [RW-1:0] free_idx;
    logic [RW-1:0] lru_idx;
    logic [RW-1:0] victim;

    assign k    = req.key[KW-1:0];
    assign v    = req.value[VW-1:0];
    assign full = (count_reg == CW'(CAPACITY));

    // tag compare and slot pick, all slots in parallel
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == k)
            begin
                hit_any = 1'b1;
                hit_idx = RW'(i);
            end
            if (!valid_reg[i])
                free_idx = RW'(i);
            if (valid_reg[i] && rank_reg[i] == RW'(CAPACITY - 1))
                lru_idx = RW'(i);
        end
        hit_rank = rank_reg[hit_idx];
        hit_val  = val_reg[hit_idx];
        victim   = full ? lru_idx : free_idx;
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_next[i] = valid_reg[i];
            key_next[i]   = key_reg[i];
            val_next[i]   = val_reg[i];
            rank_next[i]  = rank_reg[i];
        end

        case (req.mode) inside
            MODE_GET, MODE_PUT:
            begin
                if (hit_any)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (RW'(i) == hit_idx)
                        begin
                            rank_next[i] = '0;
                            if (req.mode == MODE_PUT)
                                val_next[i] = v;
                        end
                        else if (valid_reg[i] && rank_reg[i] < hit_rank)
                            rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                else if (req.mode == MODE_PUT)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (RW'(i) == victim)
                        begin
                            valid_next[i] = 1'b1;
                            key_next[i]   = k;
                            val_next[i]   = v;
                            rank_next[i]  = '0;
                        end
                        else if (valid_reg[i])
                            rank_next[i] = rank_reg[i] + RW'(1);
                    end
                    if (!full)
                        count_next = count_reg + CW'(1);
                end
            end
            MODE_ERASE:
            begin
                if (hit_any)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (RW'(i) == hit_idx)
                            valid_next[i] = 1'b0;
                        else if (valid_reg[i] && rank_reg[i] > hit_rank)
                            rank_next[i] = rank_reg[i] - RW'(1);
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    valid_next[i] = 1'b0;
                count_next = '0;
            end
        endcase

        rsp.found       = hit_any && (req.mode != MODE_CLEAR);
        rsp.value_out   = (hit_any && req.mode == MODE_GET) ? DATA_W'(hit_val) : '0;
        rsp.entry_count = COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else if (upd)
        begin
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_reg[i] <= key_next[i];
                val_reg[i] <= val_next[i];
            end
        end
    end

endmodule

[rtl/core/lru_key_value_cache.sv]
// Channel   Words                       Handshake            Direction
// req       mode, key, value            req_valid/req_stall  into block
// rsp       found, value_out, entry_count rsp_valid/rsp_stall out of block
//
// One word per cycle sustained while rsp is not stalled; an accepted req word passes
// the input register, then the single-pass slot update (tag compare over all slots,
// recency rank update and result) into the result register, where rsp is valid.
// Reset empties the store at once: no clearing pass, stored keys and values
// are not reset and are only read through a valid slot.
// A stalled rsp holds the result register; req stalls only when the input
// register is full and cannot move into the held result register.
module lru_key_value_cache #(
    parameter int CAPACITY   = lkv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  lkv_pkg::mode_t               mode,
    input  logic [lkv_pkg::DATA_W-1:0]   key,
    input  logic [lkv_pkg::DATA_W-1:0]   value,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         found,
    output logic [lkv_pkg::DATA_W-1:0]   value_out,
    output logic [lkv_pkg::COUNT_W-1:0]  entry_count
);
    import lkv_pkg::*;

    // input register: the word waiting for its pass through the store
    logic     s1_valid_reg;
    logic     s1_valid_next;
    lkv_req_t s1_reg;

    // result register
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    lkv_rsp_t rsp_reg;

    lkv_rsp_t rsp_comb;
    logic     accept;
    logic     adv;

    // the input word moves on when the result register is empty or being drained
    assign adv       = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !adv;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (adv)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.mode  <= mode;
            s1_reg.key   <= key;
            s1_reg.value <= value;
        end
        if (adv)
            rsp_reg <= rsp_comb;
    end

    // store state commits in the same cycle the result is captured
    lkv_store #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (adv),
        .req   (s1_reg),
        .rsp   (rsp_comb)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign found       = rsp_reg.found;
    assign value_out   = rsp_reg.value_out;
    assign entry_count = rsp_reg.entry_count;

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("req stalled without a held result");

    // a word leaving the input register always shows up as a result
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> rsp_valid)
        else $error("advanced word produced no result");

    // clear leaves an empty store and reports no hit
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.mode == MODE_CLEAR) |=> (entry_count == '0 && !found))
        else $error("clear did not empty the store");

    // value_out is only nonzero on a get hit
    a_get_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.mode != MODE_GET) |=> (value_out == '0))
        else $error("value returned on a non-get word");

endmodule
